// File: src/dpq_pkg.sv
package dpq_pkg;

  localparam int KIND_W       = 2;
  localparam int CLIENT_W     = 20;
  localparam int PRIO_W       = 24;
  localparam int MULT_W       = 11;
  localparam int CAPACITY_DEF = 1024;

  // Each registered tree stage merges up to 2**TREE_STEP_LG nodes into one.
  localparam int TREE_STEP_LG = 3;

  localparam logic [MULT_W-1:0] MULT_MAX = {MULT_W{1'b1}};
  localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(1);

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MAX = 2'd1,
    OP_POP_MIN = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_APPLY
  } st_t;

  // One queue slot.
  typedef struct packed {
    logic                valid;
    logic [PRIO_W-1:0]   prio;
    logic [CLIENT_W-1:0] client;
    logic [MULT_W-1:0]   mult;
  } cell_t;

  // What a cell reports into the reduction tree.
  typedef struct packed {
    logic                hit;
    logic [CLIENT_W-1:0] client;
  } probe_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                apply;
    op_t                 op;
    logic [CLIENT_W-1:0] client;
    logic [PRIO_W-1:0]   prio;
    logic                merge;
    logic                full;
    logic                min_dec;
  } cmd_t;

  function automatic int tree_stages(input int n);
    int lg;
    lg = $clog2(n);
    return (lg + TREE_STEP_LG - 1) / TREE_STEP_LG;
  endfunction

endpackage

// File: src/dpq_in_if.sv
interface dpq_in_if import dpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CLIENT_W-1:0] client;
  logic [PRIO_W-1:0]   priority_req;

  modport source (output valid, output kind, output client, output priority_req,
                  input ready);
  modport sink   (input valid, input kind, input client, input priority_req,
                  output ready);
endinterface

// File: src/dpq_out_if.sv
interface dpq_out_if import dpq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CLIENT_W-1:0] popped_client;
  logic                found;

  modport source (output valid, output popped_client, output found, input ready);
  modport sink   (input valid, input popped_client, input found, output ready);
endinterface

// File: src/dpq_cell.sv
module dpq_cell import dpq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   head,
  input  cmd_t   cmd,
  input  cell_t  left,
  input  cell_t  right,
  output cell_t  cur,
  output probe_t probe
);

  cell_t cur_next;
  logic  hit;
  logic  last;
  logic  shift_in;
  logic  take_new;

  assign hit  = cur.valid && (cur.prio == cmd.prio);
  assign last = cur.valid && !right.valid;

  assign probe.hit    = hit;
  assign probe.client = last ? cur.client : '0;

  // Sorted insert: entries above the new key move up by one slot, and the
  // slot at the boundary takes the new entry.
  assign shift_in = !head && left.valid && (left.prio > cmd.prio);
  assign take_new = (head || (left.valid && (left.prio < cmd.prio))) &&
                    (!cur.valid || (cur.prio > cmd.prio));

  always_comb begin
    cur_next = cur;
    if (cmd.apply) begin
      case (cmd.op)
        OP_INSERT: begin
          if (cmd.merge) begin
            if (hit && (cur.mult != MULT_MAX)) begin
              cur_next.mult = cur.mult + MULT_ONE;
            end
          end else if (!cmd.full) begin
            if (shift_in) begin
              cur_next = left;
            end else if (take_new) begin
              cur_next.valid  = 1'b1;
              cur_next.prio   = cmd.prio;
              cur_next.client = cmd.client;
              cur_next.mult   = MULT_ONE;
            end
          end
        end
        OP_POP_MIN: begin
          if (cmd.min_dec) begin
            if (head) begin
              cur_next.mult = cur.mult - MULT_ONE;
            end
          end else begin
            cur_next = right;
          end
        end
        OP_POP_MAX: begin
          if (last) begin
            if (cur.mult > MULT_ONE) begin
              cur_next.mult = cur.mult - MULT_ONE;
            end else begin
              cur_next.valid = 1'b0;
            end
          end
        end
        default: begin
          cur_next = cur;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

// File: src/dpq_or_tree.sv
module dpq_or_tree import dpq_pkg::*; #(
  parameter int N = CAPACITY_DEF,
  parameter int W = 1
) (
  input  logic         clk,
  input  logic [W-1:0] leaves [N],
  output logic [W-1:0] root
);

  localparam int LG = $clog2(N);
  localparam int P  = 1 << LG;
  localparam int ST = tree_stages(N);

  logic [W-1:0] lvl [ST+1][P];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign lvl[0][i] = leaves[i];
    end else begin : g_pad
      assign lvl[0][i] = '0;
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_stage
    localparam int IN_LG = LG - TREE_STEP_LG * s;
    localparam int STEP  = (IN_LG > TREE_STEP_LG) ? TREE_STEP_LG : IN_LG;
    localparam int OUTN  = 1 << (IN_LG - STEP);
    localparam int G     = 1 << STEP;
    for (genvar j = 0; j < P; j++) begin : g_node
      if (j < OUTN) begin : g_live
        logic [W-1:0] red;
        logic [W-1:0] q;
        always_comb begin
          red = '0;
          for (int k = 0; k < G; k++) begin
            red = red | lvl[s][j*G + k];
          end
        end
        always_ff @(posedge clk) begin
          q <= red;
        end
        assign lvl[s+1][j] = q;
      end else begin : g_idle
        assign lvl[s+1][j] = '0;
      end
    end
  end

  assign root = lvl[ST][0];

endmodule

// File: src/double_ended_priority_queue.sv
// Channel  Role    Payload                          Moves when
// req      sink    kind, client, priority_req       req.valid && req.ready
// rsp      source  popped_client, found             rsp.valid && rsp.ready
//
// An insert or pop passes through an accepting step, a wait state that covers
// the registered stages of the OR tree that finds a matching key and the client
// of the highest entry, and an apply step. A transaction of the unused kind is
// accepted, changes nothing and leaves the queue idle. Synchronous reset clears
// every cell's valid bit. A pop holds in its apply step while the previous
// response transaction has not been taken.

module double_ended_priority_queue import dpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst,
  dpq_in_if.sink   req,
  dpq_out_if.source rsp
);

  // Latency of the reduction tree and the wait counter that covers it.
  localparam int TREE_LAT = tree_stages(CAPACITY);
  localparam int CNT_W    = $clog2(TREE_LAT + 1);
  localparam int LEAF_W   = $bits(probe_t);

  // The queue is a row of cells kept sorted by ascending priority and
  // packed toward cell zero. The lowest entry always sits in cell zero; the
  // highest is the last valid cell, which every cell can recognize from its
  // right neighbor.
  cell_t        cells  [CAPACITY];
  probe_t       probes [CAPACITY];
  logic [LEAF_W-1:0] leaves [CAPACITY];
  logic [LEAF_W-1:0] root;
  probe_t       root_probe;

  st_t               state;
  st_t               state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  // The accepted request is held here while the tree settles.
  op_t                 op;
  logic [CLIENT_W-1:0] req_client;
  logic [PRIO_W-1:0]   req_prio;

  logic                out_valid;
  logic [CLIENT_W-1:0] out_client;
  logic                out_found;

  logic  accept;
  logic  finish;
  logic  is_pop;
  cmd_t  cmd;

  assign req.ready         = (state == ST_IDLE);
  assign accept            = req.valid && req.ready;
  assign rsp.valid         = out_valid;
  assign rsp.popped_client = out_client;
  assign rsp.found         = out_found;

  assign is_pop = (op == OP_POP_MAX) || (op == OP_POP_MIN);
  assign root_probe = probe_t'(root);

  // State machine: accept, wait out the tree latency, then apply; the unused kind stays idle.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    finish     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (op_t'(req.kind) != OP_NONE)) begin
          state_next = ST_WAIT;
          cnt_next   = CNT_W'(TREE_LAT - 1);
        end
      end
      ST_WAIT: begin
        if (cnt == '0) begin
          state_next = ST_APPLY;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ST_APPLY: begin
        // A pop needs the response register to be free or freeing now.
        if (!is_pop || !out_valid || rsp.ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= op_t'(req.kind);
      req_client <= req.client;
      req_prio   <= req.priority_req;
    end
  end

  // Broadcast command. A matching key anywhere turns an insert into a
  // multiplicity bump; a full row drops a new key.
  assign cmd.apply   = finish;
  assign cmd.op      = op;
  assign cmd.client  = req_client;
  assign cmd.prio    = req_prio;
  assign cmd.merge   = root_probe.hit;
  assign cmd.full    = cells[CAPACITY-1].valid;
  assign cmd.min_dec = cells[0].valid && (cells[0].mult > MULT_ONE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left;
    cell_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    dpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .head  (i == 0),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .cur   (cells[i]),
      .probe (probes[i])
    );

    assign leaves[i] = LEAF_W'(probes[i]);
  end

  dpq_or_tree #(
    .N (CAPACITY),
    .W (LEAF_W)
  ) u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  // Response register. Pop-min reads cell zero directly; pop-max takes the
  // client of the last valid cell from the tree. An empty row answers with
  // client zero and found clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish && is_pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && is_pop) begin
      out_found <= cells[0].valid;
      if (op == OP_POP_MIN) begin
        out_client <= cells[0].valid ? cells[0].client : '0;
      end else begin
        out_client <= root_probe.client;
      end
    end
  end

  // The row stays packed: a full row has its head occupied.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    cells[CAPACITY-1].valid |-> cells[0].valid)
    else $error("queue row lost its packing");

  // The two lowest entries stay in strictly ascending order.
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cells[1].valid |-> (cells[0].valid && (cells[0].prio < cells[1].prio)))
    else $error("queue row out of order");

  // An insert into a row with room always leaves the head occupied.
  a_insert: assert property (@(posedge clk) disable iff (rst)
    (finish && (op == OP_INSERT) && !cells[CAPACITY-1].valid) |=> cells[0].valid)
    else $error("insert left the queue empty");

  // A response that found nothing carries client zero.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_client == '0))
    else $error("empty pop returned a nonzero client");

endmodule
